### design/keypad_pin_lock_controller_top_defines.svh
// assertion macros for the keypad pin lock controller
`ifndef KEYPAD_PIN_LOCK_CONTROLLER_TOP_DEFINES_SVH
`define KEYPAD_PIN_LOCK_CONTROLLER_TOP_DEFINES_SVH

// antecedent holds, consequent must hold in the same cycle
`define KPLC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define KPLC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kplc_pkg.sv
`default_nettype none
package kplc_pkg;

    localparam int PIN_DIGITS_DEF = 4;

    localparam logic [15:0] PIN_CODE_RST = 16'h1234;
    localparam logic [15:0] TPS_RST      = 16'd31;
    localparam logic [7:0]  TIMEOUT_RST  = 8'd5;
    localparam logic [7:0]  REMOTE_RST   = 8'd84;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_PIN_CODE = 2'd0,
        REG_TPS      = 2'd1,
        REG_TIMEOUT  = 2'd2,
        REG_REMOTE   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_WAKE   = 3'd1,
        OP_SERIAL = 3'd2,
        OP_DIGIT  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_ENTER  = 3'd5
    } t_opcode;

    typedef enum logic [3:0] {
        ST_NONE       = 4'd0,
        ST_STORED     = 4'd1,
        ST_ERASED     = 4'd2,
        ST_GRANTED    = 4'd3,
        ST_DENIED     = 4'd4,
        ST_INCOMPLETE = 4'd5,
        ST_TIMEOUT    = 4'd6,
        ST_WAKE_OFF   = 4'd7,
        ST_WAKE_ON    = 4'd8
    } t_status;

    typedef struct packed {
        logic [15:0] pin_code;
        logic [15:0] ticks_per_second;
        logic [7:0]  idle_limit;
        logic [7:0]  remote_command;
    } t_cfg;

    typedef struct packed {
        logic [3:0] echo_digit;
        logic [2:0] entered_count;
        logic       screen_on;
        logic [3:0] status;
    } t_result;

endpackage
`default_nettype wire

### design/kplc_cfg.sv
`default_nettype none
module kplc_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [kplc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [kplc_pkg::CFG_DW-1:0]  i_cfg_data,
    output kplc_pkg::t_cfg                    o_cfg
);
    import kplc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_code         <= PIN_CODE_RST;
            r_cfg.ticks_per_second <= TPS_RST;
            r_cfg.idle_limit       <= TIMEOUT_RST;
            r_cfg.remote_command   <= REMOTE_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_PIN_CODE: r_cfg.pin_code         <= i_cfg_data;
                REG_TPS:      r_cfg.ticks_per_second <= i_cfg_data;
                REG_TIMEOUT:  r_cfg.idle_limit       <= i_cfg_data[7:0];
                REG_REMOTE:   r_cfg.remote_command   <= i_cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

### design/kplc_core.sv
`default_nettype none
module kplc_core #(
    parameter int PIN_DIGITS = kplc_pkg::PIN_DIGITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [2:0]    i_opcode,
    input  wire logic [3:0]    i_digit_value,
    input  wire logic [7:0]    i_serial_byte,
    input  wire kplc_pkg::t_cfg i_cfg,
    output kplc_pkg::t_result  o_result
);
    import kplc_pkg::*;

    localparam int CW = $clog2(PIN_DIGITS + 1);
    localparam int IW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam logic [CW-1:0] FULL = CW'(PIN_DIGITS);

    logic [15:0]   r_tick, n_tick;
    logic [7:0]    r_sec, n_sec;
    logic          r_screen, n_screen;
    logic [CW-1:0] r_count, n_count;
    logic [3:0]    r_digits [PIN_DIGITS];

    logic [3:0]    w_pin_dig [PIN_DIGITS];
    logic          w_match;
    logic          w_store;
    logic [15:0]   w_tick_inc;
    logic [7:0]    w_sec_inc;
    t_status       w_status;
    logic [3:0]    w_echo;

    // pin digit i sits in nibble PIN_DIGITS-1-i, nibbles past the register read as zero
    for (genvar gi = 0; gi < PIN_DIGITS; gi++) begin : g_pin
        if (PIN_DIGITS - 1 - gi < 4) begin : g_in
            assign w_pin_dig[gi] = i_cfg.pin_code[4*(PIN_DIGITS-1-gi) +: 4];
        end else begin : g_out
            assign w_pin_dig[gi] = 4'd0;
        end
    end

    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < PIN_DIGITS; i++) begin
            if (r_digits[i] != w_pin_dig[i]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_tick_inc = r_tick + 16'd1;
    assign w_sec_inc  = r_sec + 8'd1;

    always_comb begin
        n_tick   = r_tick;
        n_sec    = r_sec;
        n_screen = r_screen;
        n_count  = r_count;
        w_status = ST_NONE;
        w_echo   = 4'd0;
        w_store  = 1'b0;
        unique case (t_opcode'(i_opcode))
            OP_TICK: begin
                if (r_screen) begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= i_cfg.ticks_per_second) begin
                        n_tick = 16'd0;
                        n_sec  = w_sec_inc;
                        if (w_sec_inc >= i_cfg.idle_limit) begin
                            n_sec    = 8'd0;
                            n_screen = 1'b0;
                            w_status = ST_TIMEOUT;
                        end
                    end
                end
            end
            OP_WAKE, OP_SERIAL: begin
                if (t_opcode'(i_opcode) == OP_WAKE ||
                    i_serial_byte == i_cfg.remote_command) begin
                    n_tick   = 16'd0;
                    n_sec    = 8'd0;
                    n_count  = '0;
                    n_screen = !r_screen;
                    w_status = r_screen ? ST_WAKE_OFF : ST_WAKE_ON;
                end
            end
            OP_DIGIT: begin
                if (r_screen) begin
                    n_tick = 16'd0;
                    n_sec  = 8'd0;
                    if (i_digit_value <= 4'd9 && r_count < FULL) begin
                        w_store  = 1'b1;
                        n_count  = r_count + CW'(1);
                        w_status = ST_STORED;
                        w_echo   = i_digit_value;
                    end
                end
            end
            OP_CLEAR: begin
                if (r_screen) begin
                    n_tick = 16'd0;
                    n_sec  = 8'd0;
                    if (r_count != '0) begin
                        n_count  = r_count - CW'(1);
                        w_status = ST_ERASED;
                    end
                end
            end
            OP_ENTER: begin
                if (r_screen) begin
                    n_tick  = 16'd0;
                    n_sec   = 8'd0;
                    n_count = '0;
                    if (r_count == FULL) begin
                        w_status = w_match ? ST_GRANTED : ST_DENIED;
                    end else begin
                        w_status = ST_INCOMPLETE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= 16'd0;
            r_sec    <= 8'd0;
            r_screen <= 1'b1;
            r_count  <= '0;
        end else if (i_fire) begin
            r_tick   <= n_tick;
            r_sec    <= n_sec;
            r_screen <= n_screen;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_store) begin
            r_digits[r_count[IW-1:0]] <= i_digit_value;
        end
    end

    always_comb begin
        o_result.status        = w_status;
        o_result.screen_on     = n_screen;
        o_result.entered_count = 3'(n_count);
        o_result.echo_digit    = w_echo;
    end
endmodule
`default_nettype wire

### design/kplc_skid.sv
`default_nettype none
module kplc_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire kplc_pkg::t_result i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_pop_ready,
    output kplc_pkg::t_result      o_data
);
    import kplc_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop = r_main_valid && i_pop_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
                n_main       = i_data;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
endmodule
`default_nettype wire

### design/keypad_pin_lock_controller_top.sv
// keypad pin lock controller
// input stream carries one event per transfer: tuser is the event kind
// (tick, wake, serial byte, digit, clear, enter), tdata the digit and byte.
// output stream carries exactly one result per event: status, screen flag,
// digit count and echoed digit.
// configuration is a plain write port (pin code, ticks per second, timeout
// seconds, remote command), to be written only while no event is in flight;
// the user must keep to this, as the block does not enforce it.
// throughput: one event per cycle while s_axis_tready is high; all event
// logic is one pass of combinational logic between the state registers and
// the output register. the output side has a two-entry skid, so
// s_axis_tready depends only on local state; when the receiver stalls two
// results are held and then s_axis_tready drops until the output moves again.
// reset: state cleared, screen on, empty entry, registers at defaults,
// no results pending.
`default_nettype none
module keypad_pin_lock_controller_top #(
    parameter int PIN_DIGITS = kplc_pkg::PIN_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [kplc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [kplc_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // digit_value [3:0], serial_byte [11:4], zero [15:12]
    input  wire logic [15:0]                  s_axis_tdata,
    // opcode [2:0]
    input  wire logic [2:0]                   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // status [3:0], screen_on [4], entered_count [7:5], echo_digit [11:8], zero [15:12]
    output logic [15:0]                       m_axis_tdata
);
    import kplc_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result w_out;
    logic    w_fire;

    assign w_fire = s_axis_tvalid && s_axis_tready;

    kplc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    kplc_core #(
        .PIN_DIGITS (PIN_DIGITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_opcode      (s_axis_tuser),
        .i_digit_value (s_axis_tdata[3:0]),
        .i_serial_byte (s_axis_tdata[11:4]),
        .i_cfg         (w_cfg),
        .o_result      (w_result)
    );

    kplc_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_fire),
        .i_data      (w_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = {4'd0, w_out};
endmodule
`default_nettype wire

### design/kplc_checker.sv
`default_nettype none
`include "keypad_pin_lock_controller_top_defines.svh"
module kplc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_cfg_we,
    input wire logic [kplc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input wire logic [kplc_pkg::CFG_DW-1:0]  i_cfg_data,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [15:0]                  s_axis_tdata,
    input wire logic [2:0]                   s_axis_tuser,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [15:0]                  m_axis_tdata
);
    import kplc_pkg::*;

    logic [3:0] w_status;
    logic       w_screen;
    logic [2:0] w_count;
    logic [3:0] w_echo;
    logic       w_unused;

    assign w_status = m_axis_tdata[3:0];
    assign w_screen = m_axis_tdata[4];
    assign w_count  = m_axis_tdata[7:5];
    assign w_echo   = m_axis_tdata[11:8];
    assign w_unused = ^{i_cfg_we, i_cfg_addr, i_cfg_data, s_axis_tvalid, s_axis_tready,
                        s_axis_tdata, s_axis_tuser};

    // stalled result holds
    `KPLC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // enter and toggle events always leave an empty entry
    `KPLC_ASSERT_IMP(a_entry_reset, i_clk, i_rst_n,
        m_axis_tvalid && (w_status == ST_GRANTED || w_status == ST_DENIED ||
        w_status == ST_INCOMPLETE || w_status == ST_WAKE_OFF || w_status == ST_WAKE_ON),
        w_count == 3'd0, "entry not emptied")

    // screen flag agrees with the screen status codes
    `KPLC_ASSERT_IMP(a_screen_code, i_clk, i_rst_n,
        m_axis_tvalid && (w_status == ST_TIMEOUT || w_status == ST_WAKE_OFF ||
        w_status == ST_WAKE_ON || w_status == ST_STORED || w_status == ST_GRANTED),
        w_screen == (w_status != ST_TIMEOUT && w_status != ST_WAKE_OFF),
        "screen flag disagrees with status")

    // echo only on a stored digit, and only a decimal one; status codes stay in range
    `KPLC_ASSERT_IMP(a_echo, i_clk, i_rst_n, m_axis_tvalid,
        w_echo <= 4'd9 && (w_status == ST_STORED || w_echo == 4'd0) &&
        w_status <= ST_WAKE_ON, "bad echo digit or status code")
endmodule

bind keypad_pin_lock_controller_top kplc_checker u_kplc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_addr    (i_cfg_addr),
    .i_cfg_data    (i_cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
    import kplc_pkg::*;

    localparam int NDIG        = PIN_DIGITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam int PRINT_MAX   = 50;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] digit;
        logic [7:0] ser;
    } t_key_event;

    typedef struct packed {
        logic [15:0]           ticks;
        logic [7:0]            secs;
        logic                  screen;
        logic [NDIG-1:0][3:0]  digits;
        logic [2:0]            count;
    } t_lock_state;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;
    logic [2:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;

    keypad_pin_lock_controller_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cfg         cfg;
    t_lock_state  pred_st;
    t_lock_state  gen_st;
    t_key_event   pend_q[$];
    t_result      lock_result_q[$];
    t_key_event   ev_drv;
    t_key_event   ev_mon;
    t_result      got;
    t_result      want;
    int           err_cnt = 0;
    int           sent_cnt = 0;
    int           acc_cnt = 0;
    int           res_cnt = 0;
    int           gen_counted = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           seg_left = 0;
    int           seg_mode = 0;
    int           hold_cnt = 0;
    int           cyc = 0;
    bit           in_xfer = 1'b0;
    bit           stall_req = 1'b0;

    function automatic t_status screen_toggle(inout t_lock_state st);
        st.ticks  = '0;
        st.secs   = '0;
        st.count  = '0;
        st.screen = !st.screen;
        return st.screen ? ST_WAKE_ON : ST_WAKE_OFF;
    endfunction

    function automatic t_result lock_step(inout t_lock_state st, input t_key_event ev);
        t_result r;
        logic    match;
        r = '0;
        r.status = ST_NONE;
        case (ev.op)
            OP_TICK: begin
                if (st.screen) begin
                    st.ticks = st.ticks + 16'd1;
                    if (st.ticks >= cfg.ticks_per_second) begin
                        st.ticks = '0;
                        st.secs  = st.secs + 8'd1;
                        if (st.secs >= cfg.idle_limit) begin
                            st.secs   = '0;
                            st.screen = 1'b0;
                            r.status  = ST_TIMEOUT;
                        end
                    end
                end
            end
            OP_WAKE: begin
                r.status = screen_toggle(st);
            end
            OP_SERIAL: begin
                if (ev.ser == cfg.remote_command)
                    r.status = screen_toggle(st);
            end
            OP_DIGIT, OP_CLEAR, OP_ENTER: begin
                if (st.screen) begin
                    st.ticks = '0;
                    st.secs  = '0;
                    if (ev.op == OP_DIGIT) begin
                        if (ev.digit <= 4'd9 && st.count < NDIG) begin
                            st.digits[st.count] = ev.digit;
                            st.count     = st.count + 3'd1;
                            r.status     = ST_STORED;
                            r.echo_digit = ev.digit;
                        end
                    end else if (ev.op == OP_CLEAR) begin
                        if (st.count > 0) begin
                            st.count = st.count - 3'd1;
                            r.status = ST_ERASED;
                        end
                    end else begin
                        if (st.count == NDIG) begin
                            match = 1'b1;
                            for (int i = 0; i < NDIG; i++)
                                if (st.digits[i] != cfg.pin_code[4*(NDIG-1-i) +: 4])
                                    match = 1'b0;
                            r.status = match ? ST_GRANTED : ST_DENIED;
                        end else begin
                            r.status = ST_INCOMPLETE;
                        end
                        st.count = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        r.screen_on     = st.screen;
        r.entered_count = st.count;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got_v, int want_v);
        if (err_cnt < PRINT_MAX)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     res_cnt, what, got_v, want_v);
        err_cnt++;
    endtask

    task automatic queue_key_event(logic [2:0] op, logic [3:0] dig, logic [7:0] ser);
        t_key_event ev;
        ev.op    = op;
        ev.digit = dig;
        ev.ser   = ser;
        void'(lock_step(gen_st, ev));
        pend_q.push_back(ev);
        gen_counted++;
    endtask

    task automatic build_session_mix(int budget);
        int         kind;
        int         n;
        logic [3:0] d;
        gen_counted = 0;
        while (gen_counted < budget) begin
            if (!gen_st.screen && $urandom_range(0, 3) != 0)
                queue_key_event($urandom_range(0, 1) ? OP_WAKE : OP_SERIAL,
                                4'($urandom_range(0, 15)), cfg.remote_command);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    for (int k = 0; k < NDIG; k++)
                        if (gen_st.count > 0)
                            queue_key_event(OP_CLEAR, 4'($urandom_range(0, 15)),
                                            8'($urandom_range(0, 255)));
                    for (int k = 0; k < NDIG; k++) begin
                        d = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 9))
                                                        : cfg.pin_code[4*(NDIG-1-k) +: 4];
                        if ($urandom_range(0, 7) == 0) begin
                            queue_key_event(OP_DIGIT, 4'($urandom_range(0, 9)),
                                            8'($urandom_range(0, 255)));
                            queue_key_event(OP_CLEAR, 4'($urandom_range(0, 15)),
                                            8'($urandom_range(0, 255)));
                        end
                        queue_key_event(OP_DIGIT, d, 8'($urandom_range(0, 255)));
                    end
                    queue_key_event(OP_ENTER, 4'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255)));
                end
                4, 5: begin
                    n = $urandom_range(1, 40);
                    for (int k = 0; k < n; k++)
                        queue_key_event(OP_TICK, 4'($urandom_range(0, 15)),
                                        8'($urandom_range(0, 255)));
                end
                6: begin
                    n = $urandom_range(0, NDIG - 1);
                    for (int k = 0; k < n; k++)
                        queue_key_event(OP_DIGIT, 4'($urandom_range(0, 9)),
                                        8'($urandom_range(0, 255)));
                    queue_key_event(OP_ENTER, 4'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255)));
                end
                7: begin
                    n = $urandom_range(NDIG, NDIG + 3);
                    for (int k = 0; k < n; k++)
                        queue_key_event(OP_DIGIT, 4'($urandom_range(0, 15)),
                                        8'($urandom_range(0, 255)));
                    n = $urandom_range(0, NDIG + 2);
                    for (int k = 0; k < n; k++)
                        queue_key_event(OP_CLEAR, 4'($urandom_range(0, 15)),
                                        8'($urandom_range(0, 255)));
                end
                default: begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        queue_key_event(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                        $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                             : cfg.remote_command);
                end
            endcase
        end
    endtask

    task automatic cfg_apply(logic [15:0] pin, logic [15:0] tps, logic [7:0] tmo,
                             logic [7:0] rc);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_PIN_CODE;
        i_cfg_data <= pin;
        cfg.pin_code = pin;
        @(negedge i_clk);
        i_cfg_addr <= REG_TPS;
        i_cfg_data <= tps;
        cfg.ticks_per_second = tps;
        @(negedge i_clk);
        i_cfg_addr <= REG_TIMEOUT;
        i_cfg_data <= {8'd0, tmo};
        cfg.idle_limit = tmo;
        @(negedge i_clk);
        i_cfg_addr <= REG_REMOTE;
        i_cfg_data <= {8'd0, rc};
        cfg.remote_command = rc;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pend_q.size() != 0 || acc_cnt != sent_cnt || lock_result_q.size() != 0);
    endtask

    // sender: bursts and gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_xfer) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                ev_drv = pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= ev_drv.op;
                s_axis_tdata  <= {4'd0, ev_drv.ser, ev_drv.digit};
                sent_cnt++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern in segments, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (stall_req) begin
            stall_req = 1'b0;
            hold_cnt  = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 40);
                seg_mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (seg_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                2: m_axis_tready <= ($urandom_range(0, 9) < 3);
                default: m_axis_tready <= 1'b0;
            endcase
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        in_xfer = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_xfer = 1'b1;
                acc_cnt++;
                ev_mon.op    = s_axis_tuser;
                ev_mon.digit = s_axis_tdata[3:0];
                ev_mon.ser   = s_axis_tdata[11:4];
                lock_result_q.push_back(lock_step(pred_st, ev_mon));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[11:0]);
                if (lock_result_q.size() == 0) begin
                    flag_mismatch("unexpected result, status", int'(got.status), 0);
                end else begin
                    want = lock_result_q.pop_front();
                    if (got.status != want.status)
                        flag_mismatch("status", int'(got.status), int'(want.status));
                    if (got.screen_on != want.screen_on)
                        flag_mismatch("screen_on", int'(got.screen_on), int'(want.screen_on));
                    if (got.entered_count != want.entered_count)
                        flag_mismatch("entered_count", int'(got.entered_count),
                                      int'(want.entered_count));
                    if (got.echo_digit != want.echo_digit)
                        flag_mismatch("echo_digit", int'(got.echo_digit),
                                      int'(want.echo_digit));
                end
                res_cnt++;
            end
        end
    end

    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [15:0] pin;
        logic [15:0] tps;
        logic [7:0]  tmo;
        int          sel;

        cfg.pin_code         = PIN_CODE_RST;
        cfg.ticks_per_second = TPS_RST;
        cfg.idle_limit       = TIMEOUT_RST;
        cfg.remote_command   = REMOTE_RST;
        pred_st = '0;
        pred_st.screen = 1'b1;
        gen_st = pred_st;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: grant, deny, full entry, bad digits, clear, remote toggle, dark keys
        queue_key_event(OP_DIGIT, 4'd1, 8'd0);
        queue_key_event(OP_DIGIT, 4'd2, 8'd0);
        queue_key_event(OP_DIGIT, 4'd3, 8'd0);
        queue_key_event(OP_DIGIT, 4'd4, 8'd0);
        queue_key_event(OP_ENTER, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd9, 8'd255);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd15, 8'd0);
        queue_key_event(OP_DIGIT, 4'd10, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd5, 8'd0);
        queue_key_event(OP_ENTER, 4'd15, 8'd255);
        queue_key_event(OP_CLEAR, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd7, 8'd0);
        queue_key_event(OP_CLEAR, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd3, 8'd0);
        queue_key_event(OP_ENTER, 4'd0, 8'd0);
        queue_key_event(OP_SERIAL, 4'd0, 8'd0);
        queue_key_event(OP_SERIAL, 4'd0, 8'd255);
        queue_key_event(OP_SERIAL, 4'd0, REMOTE_RST);
        queue_key_event(OP_DIGIT, 4'd1, 8'd0);
        queue_key_event(OP_TICK, 4'd0, 8'd0);
        queue_key_event(OP_ENTER, 4'd0, 8'd0);
        queue_key_event(OP_WAKE, 4'd0, 8'd0);
        queue_key_event(OP_RSVD6, 4'd15, 8'd255);
        queue_key_event(OP_RSVD7, 4'd15, 8'd255);
        queue_key_event(OP_WAKE, 4'd0, 8'd0);
        queue_key_event(OP_SERIAL, 4'd0, REMOTE_RST);
        wait_idle();

        // low extremes: every tick with the screen on is a timeout
        cfg_apply(16'h0000, 16'd1, 8'd1, 8'd0);
        queue_key_event(OP_TICK, 4'd0, 8'd0);
        queue_key_event(OP_TICK, 4'd0, 8'd0);
        queue_key_event(OP_SERIAL, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_ENTER, 4'd0, 8'd0);
        queue_key_event(OP_DIGIT, 4'd0, 8'd0);
        queue_key_event(OP_TICK, 4'd0, 8'd0);
        queue_key_event(OP_WAKE, 4'd0, 8'd0);
        build_session_mix(120);
        wait_idle();

        // high extremes
        cfg_apply(16'h9999, 16'd65535, 8'd255, 8'd255);
        queue_key_event(OP_DIGIT, 4'd9, 8'd0);
        queue_key_event(OP_DIGIT, 4'd9, 8'd0);
        queue_key_event(OP_DIGIT, 4'd9, 8'd0);
        queue_key_event(OP_DIGIT, 4'd9, 8'd0);
        queue_key_event(OP_ENTER, 4'd0, 8'd0);
        queue_key_event(OP_SERIAL, 4'd0, 8'd255);
        queue_key_event(OP_SERIAL, 4'd0, 8'd255);
        build_session_mix(100);
        wait_idle();

        for (int p = 0; p < 11; p++) begin
            for (int k = 0; k < NDIG; k++)
                pin[4*k +: 4] = 4'($urandom_range(0, 9));
            sel = $urandom_range(0, 9);
            if (sel < 6)
                tps = 16'($urandom_range(1, 6));
            else if (sel < 8)
                tps = 16'($urandom_range(7, 300));
            else
                tps = 16'($urandom_range(1, 65535));
            tmo = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 4))
                                              : 8'($urandom_range(1, 255));
            cfg_apply(pin, tps, tmo, 8'($urandom_range(0, 255)));
            build_session_mix(120);
            // long receiver hold-off while the sender keeps going
            if (p == 2)
                stall_req = 1'b1;
            wait_idle();
        end

        repeat (5) @(posedge i_clk);
        if (lock_result_q.size() != 0)
            flag_mismatch("results never delivered", 0, lock_result_q.size());
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
